// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker file dcab_checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/dcab_pkg.sv
// ---------------------------------------------------------------------------
// dcab_pkg
// Types and constants of the detection cell argmax and box filter.
// ---------------------------------------------------------------------------
package dcab_pkg;

    localparam int CLASS_W     = 7;
    localparam int SCORE_W     = 16;
    localparam int COORD_W     = 16;
    localparam int NET_W       = 12;
    localparam int EDGE_W      = 19;
    localparam int CLIP_W      = 18;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 88;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    localparam logic [NET_W-1:0]   DEFAULT_NET_W   = 12'd640;
    localparam logic [NET_W-1:0]   DEFAULT_NET_H   = 12'd384;
    localparam logic [CLASS_W-1:0] DEFAULT_CLASSES = 7'd80;

    localparam logic [CFG_INDEX_W-1:0] REG_NET_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NET_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CLASSES    = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] box_height;
        logic signed [COORD_W-1:0] box_width;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_x;
        logic [SCORE_W-1:0]        class_threshold;
        logic [SCORE_W-1:0]        class_score;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] out_height;
        logic [COORD_W-1:0] out_width;
        logic [COORD_W-1:0] top_edge;
        logic [COORD_W-1:0] left_edge;
        logic [SCORE_W-1:0] confidence;
        logic [CLASS_W-1:0] class_id;
    } result_t;

    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] left_edge;
        logic [COORD_W-1:0] top_edge;
        logic [COORD_W-1:0] out_width;
        logic [COORD_W-1:0] out_height;
    } box_t;

    function automatic logic [CLIP_W-1:0] clip_edge(
        input logic signed [EDGE_W-1:0] v,
        input logic signed [EDGE_W-1:0] hi
    );
        logic [CLIP_W-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > hi)
        begin
            r = hi[CLIP_W-1:0];
        end
        else
        begin
            r = v[CLIP_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/dcab_box_clip.sv
// ---------------------------------------------------------------------------
// dcab_box_clip
// Clip a centre-size box to the network area and check its extent.
// ---------------------------------------------------------------------------
module dcab_box_clip
(
    input  logic signed [dcab_pkg::COORD_W-1:0] center_x,
    input  logic signed [dcab_pkg::COORD_W-1:0] center_y,
    input  logic signed [dcab_pkg::COORD_W-1:0] box_width,
    input  logic signed [dcab_pkg::COORD_W-1:0] box_height,
    input  logic [dcab_pkg::NET_W-1:0]          net_width,
    input  logic [dcab_pkg::NET_W-1:0]          net_height,
    output dcab_pkg::box_t                      box
);
    import dcab_pkg::*;

    logic [NET_W-1:0]         nw_eff;
    logic [NET_W-1:0]         nh_eff;
    logic signed [EDGE_W-1:0] hx;
    logic signed [EDGE_W-1:0] hy;
    logic signed [EDGE_W-1:0] cx2;
    logic signed [EDGE_W-1:0] cy2;
    logic signed [EDGE_W-1:0] wx;
    logic signed [EDGE_W-1:0] hh;
    logic [CLIP_W-1:0]        l;
    logic [CLIP_W-1:0]        r;
    logic [CLIP_W-1:0]        t;
    logic [CLIP_W-1:0]        b;
    logic                     size_pos;

    always_comb
    begin
        nw_eff = (net_width == '0) ? DEFAULT_NET_W : net_width;
        nh_eff = (net_height == '0) ? DEFAULT_NET_H : net_height;
        hx     = signed'({2'b00, nw_eff - 12'd1, 5'b00000});
        hy     = signed'({2'b00, nh_eff - 12'd1, 5'b00000});
        cx2    = signed'({{2{center_x[COORD_W-1]}}, center_x, 1'b0});
        cy2    = signed'({{2{center_y[COORD_W-1]}}, center_y, 1'b0});
        wx     = signed'({{3{box_width[COORD_W-1]}}, box_width});
        hh     = signed'({{3{box_height[COORD_W-1]}}, box_height});
        l      = clip_edge(cx2 - wx, hx);
        r      = clip_edge(cx2 + wx, hx);
        t      = clip_edge(cy2 - hh, hy);
        b      = clip_edge(cy2 + hh, hy);

        size_pos = !box_width[COORD_W-1] && (box_width != '0)
                && !box_height[COORD_W-1] && (box_height != '0);

        box.valid      = size_pos && (r > l) && (b > t);
        box.left_edge  = l[COORD_W:1];
        box.top_edge   = t[COORD_W:1];
        box.out_width  = r[COORD_W:1] - l[COORD_W:1];
        box.out_height = b[COORD_W:1] - t[COORD_W:1];
    end

endmodule

// File: rtl/detection_cell_argmax_box_filter.sv
// ---------------------------------------------------------------------------
// detection_cell_argmax_box_filter
// Running class argmax per grid cell, then box clip and detection filter.
// ---------------------------------------------------------------------------
//  channel   dir  signals                          payload
//  s_axis    in   tvalid tready tdata[95:0] tlast  one class score, box, last class
//  m_axis    out  tvalid tready tdata[87:0]        one detection per kept cell
//  cfg       in   cfg_we cfg_index cfg_data        net size, class count
//
//  One beat per cycle in, unless a stalled result holds the input register.
//  Argmax compare and box clip sit between the input and result registers.
//  Reset clears the argmax state and loads 640 x 384 and 80 classes.
//  A stalled result holds in the output register; input stalls only when
//  both the input register and the result register are full.
// ---------------------------------------------------------------------------
module detection_cell_argmax_box_filter
#(
    parameter int NUM_CLASSES = 80
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // class_score, class_threshold, center_x, center_y, box_width, box_height
    input  logic [dcab_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                 s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // class_id, confidence, left_edge, top_edge, out_width, out_height, pad
    output logic [dcab_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                 cfg_we,
    input  logic [dcab_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dcab_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import dcab_pkg::*;

    localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam logic [CW-1:0] LAST_IDX = CW'(NUM_CLASSES - 1);

    logic               a_valid_reg;
    in_item_t           a_item_reg;
    logic               a_last_reg;
    logic [SCORE_W-1:0] best_score_reg;
    logic [CW-1:0]      best_index_reg;
    logic [SCORE_W-1:0] best_thr_reg;
    logic [CW-1:0]      cnt_reg;
    logic               out_valid_reg;
    result_t            out_data_reg;
    logic [NET_W-1:0]   net_width_reg;
    logic [NET_W-1:0]   net_height_reg;
    logic [CLASS_W-1:0] classes_reg;

    logic [SCORE_W-1:0] best_score_next;
    logic [CW-1:0]      best_index_next;
    logic [SCORE_W-1:0] best_thr_next;
    logic [CW-1:0]      cnt_next;
    logic [SCORE_W-1:0] thr_base;
    logic [CLASS_W-1:0] cls;
    logic               emit;
    logic               adv;
    result_t            out_data_next;
    box_t               box;

    dcab_box_clip u_box
    (
        .center_x   (a_item_reg.center_x),
        .center_y   (a_item_reg.center_y),
        .box_width  (a_item_reg.box_width),
        .box_height (a_item_reg.box_height),
        .net_width  (net_width_reg),
        .net_height (net_height_reg),
        .box        (box)
    );

    assign adv           = a_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !a_valid_reg || adv;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_data_reg};

    always_comb
    begin
        thr_base = (cnt_reg == '0) ? a_item_reg.class_threshold : best_thr_reg;
        if (a_item_reg.class_score > best_score_reg)
        begin
            best_score_next = a_item_reg.class_score;
            best_index_next = cnt_reg;
            best_thr_next   = a_item_reg.class_threshold;
        end
        else
        begin
            best_score_next = best_score_reg;
            best_index_next = best_index_reg;
            best_thr_next   = thr_base;
        end
        cnt_next = (cnt_reg < LAST_IDX) ? cnt_reg + 1'b1 : cnt_reg;
        cls      = CLASS_W'(best_index_next);
        emit     = a_last_reg && (cls < classes_reg)
                && (best_score_next >= best_thr_next) && box.valid;

        out_data_next.class_id   = cls;
        out_data_next.confidence = best_score_next;
        out_data_next.left_edge  = box.left_edge;
        out_data_next.top_edge   = box.top_edge;
        out_data_next.out_width  = box.out_width;
        out_data_next.out_height = box.out_height;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            best_score_reg <= '0;
            best_index_reg <= '0;
            best_thr_reg   <= '0;
            cnt_reg        <= '0;
            net_width_reg  <= DEFAULT_NET_W;
            net_height_reg <= DEFAULT_NET_H;
            classes_reg    <= DEFAULT_CLASSES;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                a_valid_reg <= 1'b0;
            end

            if (adv)
            begin
                out_valid_reg <= emit;
                if (a_last_reg)
                begin
                    best_score_reg <= '0;
                    best_index_reg <= '0;
                    best_thr_reg   <= '0;
                    cnt_reg        <= '0;
                end
                else
                begin
                    best_score_reg <= best_score_next;
                    best_index_reg <= best_index_next;
                    best_thr_reg   <= best_thr_next;
                    cnt_reg        <= cnt_next;
                end
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NET_WIDTH:  net_width_reg  <= cfg_data[NET_W-1:0];
                    REG_NET_HEIGHT: net_height_reg <= cfg_data[NET_W-1:0];
                    REG_CLASSES:    classes_reg    <= cfg_data[CLASS_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            a_item_reg <= in_item_t'(s_axis_tdata);
            a_last_reg <= s_axis_tlast;
        end
        if (adv && emit)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// File: rtl/dcab_checker.sv
// ---------------------------------------------------------------------------
// dcab_checker
// Port-level checks of the detection cell argmax and box filter.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dcab_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic                             s_axis_tlast,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [dcab_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    // a fresh result beat comes from a last-class beat taken through the input register
    `ASSERT_IMPL(a_out_from_last, clk, rst_n, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
    // input backpressure only while the result side is stalled
    `ASSERT_IMPL(a_in_stall, clk, rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule

bind detection_cell_argmax_box_filter dcab_checker u_dcab_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
